// File: design/prur_pkg.sv
// ----------------------------------------------------------------------------
// prur_pkg: shared types and constants for the permutation rank/unrank block
// Element count, field widths, transfer structs, the digit weight table and
// the control groups between the sequencer and the cell row.
// ----------------------------------------------------------------------------
package prur_pkg;

    localparam int ELEMENTS = 8;
    localparam int EL_BITS  = 3;
    localparam int PERM_W   = 24;
    localparam int RANK_W   = 16;
    localparam int IDX_W    = $clog2(ELEMENTS);
    localparam int CNT_W    = $clog2(ELEMENTS + 1);

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic {
        OP_RANK   = 1'b0,
        OP_UNRANK = 1'b1
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic              op;
        logic [PERM_W-1:0] perm_in;
        logic [RANK_W-1:0] rank_in;
    } req_t;

    typedef struct packed {
        logic [PERM_W-1:0] perm_out;
        logic [RANK_W-1:0] rank_out;
        logic              parity;
        logic              bad_input;
    } rsp_t;

    // Sequencer to cells
    typedef struct packed {
        logic load;
        logic shift;
        idx_t key;
    } cell_ctrl_t;

    // Sequencer to top
    typedef struct packed {
        logic                busy;
        logic                last;
        logic                unrank;
        idx_t                q;
        logic [ELEMENTS-1:0] q_hot;
        logic [RANK_W-1:0]   rank_fin;
        logic                parity_fin;
    } seq_stat_t;

    // [i][m] = m * i!
    typedef logic [ELEMENTS-1:0][ELEMENTS-1:0][RANK_W-1:0] mult_tab_t;

    function automatic int fact(input int n);
        int f;
        f = 1;
        for (int i = 2; i <= n; i++) begin
            f = f * i;
        end
        return f;
    endfunction

    function automatic mult_tab_t mult_table();
        mult_tab_t t;
        int        f;
        t = '0;
        f = 1;
        for (int i = 0; i < ELEMENTS; i++) begin
            if (i > 1) begin
                f = f * i;
            end
            for (int m = 0; m < ELEMENTS; m++) begin
                t[i][m] = RANK_W'(m * f);
            end
        end
        return t;
    endfunction

    function automatic logic [PERM_W-1:0] identity_perm();
        logic [PERM_W-1:0] p;
        p = '0;
        for (int f = 0; f < ELEMENTS; f++) begin
            p[f*EL_BITS +: EL_BITS] = EL_BITS'(f);
        end
        return p;
    endfunction

    localparam mult_tab_t         MULT_TAB = mult_table();
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(fact(ELEMENTS) - 1);
    localparam logic [PERM_W-1:0] IDENTITY = identity_perm();

endpackage

// File: design/prur_cell.sv
// ----------------------------------------------------------------------------
// prur_cell: one position of the element row
// Holds one element (rank) or one output slot (unrank). When the removal
// point lies at or below this cell, it takes its right neighbor's value.
// ----------------------------------------------------------------------------
module prur_cell (
    input  logic                 clk,
    input  prur_pkg::cell_ctrl_t ctrl,
    input  prur_pkg::idx_t       load_val,
    input  logic                 hit,
    input  logic                 take_in,
    input  prur_pkg::idx_t       right_val,
    output prur_pkg::idx_t       val,
    output logic                 take_out,
    output logic                 match
);

    prur_pkg::idx_t val_reg;
    prur_pkg::idx_t val_next;
    logic           take;

    assign take     = take_in | hit;
    assign take_out = take;
    assign match    = (val_reg == ctrl.key);
    assign val      = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.load)
        begin
            val_next = load_val;
        end
        else if (ctrl.shift && take)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// File: design/prur_seq.sv
// ----------------------------------------------------------------------------
// prur_seq: step sequencer for the cell row
// Walks positions ELEMENTS-1 down to 1, resolves one rotation digit a step,
// picks the cell to remove and keeps the rank / residual and the parity.
// ----------------------------------------------------------------------------
module prur_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start_xfer,
    input  logic                           op,
    input  logic [prur_pkg::RANK_W-1:0]    rank_in,
    input  logic [prur_pkg::ELEMENTS-1:0]  match,
    output prur_pkg::cell_ctrl_t           ctrl,
    output prur_pkg::seq_stat_t            stat
);

    localparam int N  = prur_pkg::ELEMENTS;
    localparam int CW = prur_pkg::CNT_W;
    localparam int RW = prur_pkg::RANK_W;
    localparam int IW = prur_pkg::IDX_W;

    prur_pkg::state_t state_reg;
    prur_pkg::state_t state_next;
    prur_pkg::idx_t   step_reg;
    prur_pkg::idx_t   step_next;
    prur_pkg::idx_t   s_reg;
    prur_pkg::idx_t   s_next;
    logic [RW-1:0]    acc_reg;
    logic [RW-1:0]    acc_next;
    logic             par_reg;
    logic             par_next;
    logic             op_reg;
    logic             op_next;

    logic [CW-1:0]    ip1;
    logic [CW-1:0]    s_w;
    prur_pkg::idx_t   q_rank;
    logic [CW-1:0]    q1;
    logic [CW-1:0]    d;
    prur_pkg::idx_t   k_rank;
    prur_pkg::idx_t   k_un;
    prur_pkg::idx_t   j_un;
    logic [CW-1:0]    sum_un;
    prur_pkg::idx_t   q_un;
    prur_pkg::idx_t   q;
    prur_pkg::idx_t   k;
    logic [RW+CW-1:0] prod;
    logic [RW-1:0]    rank_step;
    logic             run;
    logic             last;

    // Digit and removal point for the current position
    always_comb
    begin
        ip1 = CW'(step_reg) + CW'(1);
        s_w = CW'(s_reg);

        // rank: physical place of element i, digit from rotation distance
        q_rank = '0;
        for (int j = 0; j < N; j++)
        begin
            if (match[j] && (IW'(j) <= step_reg))
            begin
                q_rank = IW'(j);
            end
        end
        q1 = CW'(q_rank) + CW'(1);
        if (q1 >= s_w)
        begin
            d = q1 - s_w;
        end
        else
        begin
            d = (ip1 - s_w) + q1;
        end
        k_rank = (d == ip1) ? '0 : IW'(d);

        // unrank: digit by compare against multiples of i!
        k_un = '0;
        for (int m = 1; m < N; m++)
        begin
            if ((IW'(m) <= step_reg) && (acc_reg >= prur_pkg::MULT_TAB[step_reg][m]))
            begin
                k_un = IW'(m);
            end
        end
        j_un   = (k_un == '0) ? step_reg : (k_un - IW'(1));
        sum_un = s_w + CW'(j_un);
        if (sum_un >= ip1)
        begin
            q_un = IW'(sum_un - ip1);
        end
        else
        begin
            q_un = IW'(sum_un);
        end

        q = (op_reg == prur_pkg::OP_UNRANK) ? q_un : q_rank;
        k = (op_reg == prur_pkg::OP_UNRANK) ? k_un : k_rank;

        prod      = (RW+CW)'(ip1) * (RW+CW)'(acc_reg);
        rank_step = RW'(prod) + RW'(k);
    end

    // Control and register updates
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        s_next     = s_reg;
        acc_next   = acc_reg;
        par_next   = par_reg;
        op_next    = op_reg;
        run        = 1'b0;
        last       = 1'b0;

        case (state_reg)
            prur_pkg::ST_IDLE:
            begin
                if (start_xfer)
                begin
                    state_next = prur_pkg::ST_RUN;
                    step_next  = IW'(N - 1);
                    s_next     = '0;
                    acc_next   = (op == prur_pkg::OP_UNRANK) ? rank_in : '0;
                    par_next   = 1'b0;
                    op_next    = op;
                end
            end
            prur_pkg::ST_RUN:
            begin
                run       = 1'b1;
                last      = (step_reg == IW'(1));
                step_next = step_reg - IW'(1);
                s_next    = (q == step_reg) ? '0 : q;
                par_next  = par_reg ^ (k[0] & step_reg[0]);
                if (op_reg == prur_pkg::OP_UNRANK)
                begin
                    acc_next = acc_reg - prur_pkg::MULT_TAB[step_reg][k];
                end
                else
                begin
                    acc_next = rank_step;
                end
                if (last)
                begin
                    state_next = prur_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = prur_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prur_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        s_reg    <= s_next;
        acc_reg  <= acc_next;
        par_reg  <= par_next;
        op_reg   <= op_next;
    end

    assign ctrl.load  = start_xfer;
    assign ctrl.shift = run;
    assign ctrl.key   = step_reg;

    assign stat.busy       = (state_reg == prur_pkg::ST_RUN);
    assign stat.last       = last;
    assign stat.unrank     = (op_reg == prur_pkg::OP_UNRANK);
    assign stat.q          = q;
    assign stat.q_hot      = N'(1) << q;
    assign stat.rank_fin   = acc_next;
    assign stat.parity_fin = par_next;

endmodule

// File: design/permutation_rank_unrank_eight_top.sv
// ----------------------------------------------------------------------------
// permutation_rank_unrank_eight_top: permutation <-> mixed-radix rank
// Converts an eight-element permutation to its rank (op 0) or a rank to its
// permutation (op 1), and reports inversion parity and a bad-input flag.
// Request: a transfer takes place on a rising edge with start high and busy
// low; req carries op, perm_in and rank_in and is sampled on that edge only.
// Result: done is high for exactly one cycle with rsp valid; the receiver
// cannot stall, so rsp must be captured on the edge that ends that cycle.
// Timing: after the request edge the cell row runs ELEMENTS-1 = 7 steps, one
// position per cycle; done follows in the next cycle. A new request is taken
// on the edge that delivers the result; the block holds one item at a time.
// The step count is set by the single removal per cycle in the cell row.
// Bad input (duplicate or out-of-range element, or rank above 40319) still
// runs the full 7 steps; outputs are then forced as the flag defines.
// Reset: busy and done drop at once; any item in flight is lost.
// ----------------------------------------------------------------------------
module permutation_rank_unrank_eight_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  prur_pkg::req_t  req,
    output logic            done,
    output prur_pkg::rsp_t  rsp
);

    localparam int N  = prur_pkg::ELEMENTS;
    localparam int EB = prur_pkg::EL_BITS;
    localparam int IW = prur_pkg::IDX_W;

    prur_pkg::cell_ctrl_t ctrl;
    prur_pkg::seq_stat_t  stat;

    logic                        start_xfer;
    prur_pkg::idx_t              cell_val  [N];
    prur_pkg::idx_t              cell_load [N];
    prur_pkg::idx_t              cell_right[N];
    logic [N:0]                  take;
    logic [N-1:0]                match;

    prur_pkg::req_t              req_reg;
    prur_pkg::req_t              req_next;
    logic                        bad_reg;
    logic                        bad_next;
    logic [prur_pkg::PERM_W-1:0] perm_build_reg;
    logic [prur_pkg::PERM_W-1:0] perm_build_next;
    prur_pkg::rsp_t              rsp_reg;
    prur_pkg::rsp_t              rsp_next;
    logic                        done_reg;
    logic                        done_next;

    logic [N-1:0]                seen;
    logic [EB-1:0]               fv;
    logic                        perm_bad;
    prur_pkg::idx_t              slot;

    assign start_xfer = start && !stat.busy;
    assign busy       = stat.busy;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    prur_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_xfer (start_xfer),
        .op         (req.op),
        .rank_in    (req.rank_in),
        .match      (match),
        .ctrl       (ctrl),
        .stat       (stat)
    );

    // ------------------------------------------------------------------
    // Cell row. Rank: cells hold the elements. Unrank: cells hold output
    // slot numbers. Each step removes one cell; cells above it slide down.
    // ------------------------------------------------------------------
    assign take[0] = 1'b0;

    for (genvar j = 0; j < N; j++)
    begin : g_cell
        assign cell_load[j] = (req.op == prur_pkg::OP_UNRANK) ?
                              IW'(j) : IW'(req.perm_in[j*EB +: EB]);
        if (j == N - 1)
        begin : g_end
            assign cell_right[j] = '0;
        end
        else
        begin : g_mid
            assign cell_right[j] = cell_val[j+1];
        end

        prur_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .load_val  (cell_load[j]),
            .hit       (stat.q_hot[j]),
            .take_in   (take[j]),
            .right_val (cell_right[j]),
            .val       (cell_val[j]),
            .take_out  (take[j+1]),
            .match     (match[j])
        );
    end

    // ------------------------------------------------------------------
    // Input check at request time
    // ------------------------------------------------------------------
    always_comb
    begin
        seen     = '0;
        perm_bad = 1'b0;
        fv       = '0;
        for (int f = 0; f < N; f++)
        begin
            fv = req.perm_in[f*EB +: EB];
            if ((int'(fv) >= N) || seen[fv])
            begin
                perm_bad = 1'b1;
            end
            else
            begin
                seen[fv] = 1'b1;
            end
        end
        if (req.op == prur_pkg::OP_UNRANK)
        begin
            bad_next = (req.rank_in > prur_pkg::RANK_MAX);
        end
        else
        begin
            bad_next = perm_bad;
        end
    end

    // ------------------------------------------------------------------
    // Unrank: the removed cell names the slot that receives element i.
    // Element 0 lands in the last slot left, which is already zero.
    // ------------------------------------------------------------------
    assign slot = cell_val[stat.q];

    always_comb
    begin
        perm_build_next = perm_build_reg;
        if (start_xfer)
        begin
            perm_build_next = '0;
        end
        else if (ctrl.shift)
        begin
            for (int f = 0; f < N; f++)
            begin
                if (IW'(f) == slot)
                begin
                    perm_build_next[f*EB +: EB] = EB'(ctrl.key);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register, loaded on the last step
    // ------------------------------------------------------------------
    always_comb
    begin
        req_next  = start_xfer ? req : req_reg;
        rsp_next  = rsp_reg;
        done_next = stat.last;
        if (stat.last)
        begin
            if (bad_reg)
            begin
                rsp_next.perm_out = stat.unrank ? prur_pkg::IDENTITY : req_reg.perm_in;
                rsp_next.rank_out = '0;
                rsp_next.parity   = 1'b0;
            end
            else
            begin
                rsp_next.perm_out = stat.unrank ? perm_build_next : req_reg.perm_in;
                rsp_next.rank_out = stat.unrank ? req_reg.rank_in : stat.rank_fin;
                rsp_next.parity   = stat.parity_fin;
            end
            rsp_next.bad_input = bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        perm_build_reg <= perm_build_next;
        rsp_reg        <= rsp_next;
        if (start_xfer)
        begin
            bad_reg <= bad_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef ASSERT_OFF
    // Every request transfer is answered by a result strobe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(N) done)
        else $error("result not delivered at fixed latency");

    // Row is free while a result is shown
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result strobe outside end of run");

    // A good result carries an in-range rank
    a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.bad_input) |-> (rsp.rank_out <= prur_pkg::RANK_MAX))
        else $error("rank out of range");

    // A rejected item reports zero rank and even parity
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.bad_input) |-> (rsp.rank_out == '0) && !rsp.parity)
        else $error("bad input result not cleared");
`endif

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for permutation_rank_unrank_eight_top
// Sends rank and unrank requests through the start/busy command port and
// predicts each result in the bench. Every done strobe is checked field by
// field against the oldest outstanding prediction. Stimulus is a short
// directed set, a back-to-back burst, a full drain pause, and a long random
// mix of valid, broken and out-of-range items with random sender gaps.
// ----------------------------------------------------------------------------
module testbench;

    import prur_pkg::*;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;

    // Predicted results, oldest first; one entry per accepted transfer.
    rsp_t in_flight[$];
    rsp_t oldest;
    int   fail_count = 0;

    permutation_rank_unrank_eight_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Inversion count mod 2 over the eight packed elements.
    function automatic logic inversion_parity(input logic [PERM_W-1:0] p);
        logic par;
        par = 1'b0;
        for (int i = 1; i < ELEMENTS; i++)
        begin
            for (int j = 0; j < i; j++)
            begin
                if (p[j*EL_BITS +: EL_BITS] > p[i*EL_BITS +: EL_BITS])
                begin
                    par = ~par;
                end
            end
        end
        return par;
    endfunction

    // Expected result of one request: permutation -> rank, or rank -> permutation.
    function automatic rsp_t compute_conversion(input req_t r);
        rsp_t                res;
        int                  el [ELEMENTS];
        logic [ELEMENTS-1:0] seen;
        logic                dup;
        int                  k;
        int                  tmp;
        int                  acc;
        res = '0;
        if (r.op == OP_RANK)
        begin
            // perm_in is always echoed, even when it is rejected
            res.perm_out = r.perm_in;
            seen = '0;
            dup  = 1'b0;
            for (int i = 0; i < ELEMENTS; i++)
            begin
                el[i] = int'(r.perm_in[i*EL_BITS +: EL_BITS]);
                if (el[i] >= ELEMENTS || seen[el[i]])
                begin
                    dup = 1'b1;
                end
                else
                begin
                    seen[el[i]] = 1'b1;
                end
            end
            if (dup)
            begin
                res.bad_input = 1'b1;
                return res;
            end
            res.parity = inversion_parity(r.perm_in);
            acc = 0;
            // top position down: count left rotations of prefix 0..i
            for (int i = ELEMENTS - 1; i > 0; i--)
            begin
                k = 0;
                while (el[i] != i && k < i)
                begin
                    tmp = el[0];
                    for (int j = 0; j < i; j++)
                    begin
                        el[j] = el[j+1];
                    end
                    el[i] = tmp;
                    k++;
                end
                acc = (i + 1) * acc + k;
            end
            res.rank_out = RANK_W'(acc);
        end
        else
        begin
            for (int i = 0; i < ELEMENTS; i++)
            begin
                el[i] = i;
            end
            // out-of-range rank leaves the identity in place
            if (r.rank_in <= RANK_MAX)
            begin
                acc = int'(r.rank_in);
                for (int i = 1; i < ELEMENTS; i++)
                begin
                    k   = acc % (i + 1);
                    acc = acc / (i + 1);
                    repeat (k)
                    begin
                        tmp = el[i];
                        for (int j = i; j > 0; j--)
                        begin
                            el[j] = el[j-1];
                        end
                        el[0] = tmp;
                    end
                end
            end
            for (int i = 0; i < ELEMENTS; i++)
            begin
                res.perm_out[i*EL_BITS +: EL_BITS] = EL_BITS'(el[i]);
            end
            if (r.rank_in > RANK_MAX)
            begin
                res.bad_input = 1'b1;
            end
            else
            begin
                res.rank_out = r.rank_in;
                res.parity   = inversion_parity(res.perm_out);
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checking: done is a one-cycle strobe that cannot be held off,
    // so rsp is taken on the edge that ends the strobe cycle.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (in_flight.size() == 0)
            begin
                $error("result with nothing outstanding: %h", rsp);
                fail_count++;
            end
            else
            begin
                oldest = in_flight.pop_front();
                if (rsp.perm_out !== oldest.perm_out)
                begin
                    $error("perm_out: expected %h, got %h", oldest.perm_out, rsp.perm_out);
                    fail_count++;
                end
                if (rsp.rank_out !== oldest.rank_out)
                begin
                    $error("rank_out: expected %0d, got %0d", oldest.rank_out, rsp.rank_out);
                    fail_count++;
                end
                if (rsp.parity !== oldest.parity)
                begin
                    $error("parity: expected %b, got %b", oldest.parity, rsp.parity);
                    fail_count++;
                end
                if (rsp.bad_input !== oldest.bad_input)
                begin
                    $error("bad_input: expected %b, got %b", oldest.bad_input, rsp.bad_input);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic req_t make_req(input op_t o, input logic [PERM_W-1:0] p,
                                      input logic [RANK_W-1:0] rk);
        req_t r;
        r.op      = o;
        r.perm_in = p;
        r.rank_in = rk;
        return r;
    endfunction

    // Sender gap in cycles: mostly none or short, now and then long.
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            return 0;
        end
        if (pick < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (pick < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(13, 40);
    endfunction

    // Uniform random permutation (Fisher-Yates).
    function automatic logic [PERM_W-1:0] shuffled_perm();
        int                el [ELEMENTS];
        int                j;
        int                tmp;
        logic [PERM_W-1:0] p;
        for (int i = 0; i < ELEMENTS; i++)
        begin
            el[i] = i;
        end
        for (int i = ELEMENTS - 1; i > 0; i--)
        begin
            j     = $urandom_range(0, i);
            tmp   = el[i];
            el[i] = el[j];
            el[j] = tmp;
        end
        p = '0;
        for (int i = 0; i < ELEMENTS; i++)
        begin
            p[i*EL_BITS +: EL_BITS] = EL_BITS'(el[i]);
        end
        return p;
    endfunction

    // Mostly well-formed requests; the rest is noise, duplicates and big ranks.
    // Unused fields carry random values, the block must ignore them.
    function automatic req_t random_request();
        int                pick;
        int                pos;
        int                src;
        logic [PERM_W-1:0] noise_perm;
        logic [RANK_W-1:0] noise_rank;
        logic [PERM_W-1:0] p;
        pick       = $urandom_range(0, 99);
        noise_perm = PERM_W'($urandom);
        noise_rank = RANK_W'($urandom);
        if (pick < 40)
        begin
            return make_req(OP_RANK, shuffled_perm(), noise_rank);
        end
        if (pick < 50)
        begin
            return make_req(OP_RANK, noise_perm, noise_rank);
        end
        if (pick < 56)
        begin
            // valid permutation with one element copied over another
            p   = shuffled_perm();
            pos = $urandom_range(0, ELEMENTS - 1);
            src = (pos + $urandom_range(1, ELEMENTS - 1)) % ELEMENTS;
            p[pos*EL_BITS +: EL_BITS] = p[src*EL_BITS +: EL_BITS];
            return make_req(OP_RANK, p, noise_rank);
        end
        if (pick < 90)
        begin
            return make_req(OP_UNRANK, noise_perm, RANK_W'($urandom_range(0, RANK_MAX)));
        end
        return make_req(OP_UNRANK, noise_perm, noise_rank);
    endfunction

    // One command transfer. start stays high across back-to-back items; it is
    // only dropped when a gap follows, so it never sees two updates per edge.
    task automatic transfer_item(input req_t item, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= item;
        // busy read here is its value before the edge: that decides acceptance
        do
            @(posedge clk);
        while (busy);
        in_flight.push_back(compute_conversion(item));
    endtask

    // Hold the sender off until every outstanding result has come back.
    task automatic wait_all_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (in_flight.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Identity, full reversal, one swap, rotation by one.
    task automatic test_rank_directed();
        logic [PERM_W-1:0] rev;
        logic [PERM_W-1:0] rot;
        logic [PERM_W-1:0] swp;
        for (int i = 0; i < ELEMENTS; i++)
        begin
            rev[i*EL_BITS +: EL_BITS] = EL_BITS'(ELEMENTS - 1 - i);
            rot[i*EL_BITS +: EL_BITS] = EL_BITS'((i + 1) % ELEMENTS);
        end
        swp = IDENTITY;
        swp[0 +: EL_BITS]       = EL_BITS'(1);
        swp[EL_BITS +: EL_BITS] = EL_BITS'(0);
        transfer_item(make_req(OP_RANK, IDENTITY, '0), idle_gap());
        transfer_item(make_req(OP_RANK, rev, '1), idle_gap());
        transfer_item(make_req(OP_RANK, swp, RANK_MAX), idle_gap());
        transfer_item(make_req(OP_RANK, rot, 16'h8000), idle_gap());
    endtask

    // Rank extremes, including the 7! radix boundary of the top digit.
    task automatic test_unrank_directed();
        transfer_item(make_req(OP_UNRANK, '0, '0), idle_gap());
        transfer_item(make_req(OP_UNRANK, '1, 16'd1), idle_gap());
        transfer_item(make_req(OP_UNRANK, '0, RANK_MAX), idle_gap());
        transfer_item(make_req(OP_UNRANK, '1, 16'd5039), idle_gap());
        transfer_item(make_req(OP_UNRANK, '0, 16'd5040), idle_gap());
    endtask

    // Non-permutations in rank mode, too-large ranks in unrank mode.
    task automatic test_bad_inputs();
        logic [PERM_W-1:0] dup_top;
        logic [PERM_W-1:0] dup_bottom;
        dup_top    = IDENTITY;
        dup_top[(ELEMENTS-1)*EL_BITS +: EL_BITS] = EL_BITS'(ELEMENTS - 2);
        dup_bottom = IDENTITY;
        dup_bottom[0 +: EL_BITS] = EL_BITS'(ELEMENTS - 1);
        transfer_item(make_req(OP_RANK, '0, '0), idle_gap());
        transfer_item(make_req(OP_RANK, '1, '1), idle_gap());
        transfer_item(make_req(OP_RANK, dup_top, '0), idle_gap());
        transfer_item(make_req(OP_RANK, dup_bottom, '0), idle_gap());
        transfer_item(make_req(OP_UNRANK, '1, RANK_MAX + 16'd1), idle_gap());
        transfer_item(make_req(OP_UNRANK, '0, 16'h8000), idle_gap());
        transfer_item(make_req(OP_UNRANK, '1, '1), idle_gap());
    endtask

    // Full-rate stream, start never dropped.
    task automatic test_back_to_back();
        for (int n = 0; n < 30; n++)
        begin
            transfer_item(random_request(), 0);
        end
    endtask

    // Sender stops until the pipeline is empty, then resumes.
    task automatic test_drain_pause();
        for (int n = 0; n < 5; n++)
        begin
            transfer_item(random_request(), 0);
        end
        wait_all_results();
        for (int n = 0; n < 5; n++)
        begin
            transfer_item(random_request(), idle_gap());
        end
    endtask

    // Blocks of 50: some at full rate, the rest with random gaps; some
    // blocks end in a full drain.
    task automatic test_random_mix();
        bit burst;
        for (int blk = 0; blk < 32; blk++)
        begin
            burst = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 50; n++)
            begin
                transfer_item(random_request(), burst ? 0 : idle_gap());
            end
            if ($urandom_range(0, 3) == 0)
            begin
                wait_all_results();
            end
        end
    endtask

    // Drop start, let the last results come back, then settle before checking that none is missing.
    task automatic drain_and_settle();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (in_flight.size() != 0 && waited < 200)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (16) @(posedge clk);
        if (in_flight.size() != 0)
        begin
            $error("%0d results never arrived", in_flight.size());
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        req   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_rank_directed();
        test_unrank_directed();
        test_bad_inputs();
        test_back_to_back();
        test_drain_pause();
        test_random_mix();
        drain_and_settle();

        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: a time limit far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// File: permutation_rank_unrank_eight_top.f
design/prur_pkg.sv
design/prur_cell.sv
design/prur_seq.sv
design/permutation_rank_unrank_eight_top.sv
test/testbench.sv
